### sv/tcdw_pkg.sv
// Shared types and constants of the text console decimal writer.
// No dependencies; tcdw_ctrl, tcdw_datapath, the top level and the bench import it.
`default_nettype none

package tcdw_pkg;

  // Screen geometry and cursor widths
  localparam int COLUMNS = 80;
  localparam int LINES   = 24;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int OFF_W   = 12;

  // Number conversion
  localparam int          MAX_DIGITS = 10;
  localparam int          CNT_W      = 4;
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;  // ceil(2^35 / 10)
  localparam int          RECIP_SHR  = 35;

  // Character codes
  localparam logic [7:0] ASCII_NL    = 8'd10;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ATTR_RESET  = 8'd7;

  // Operation codes of an input beat
  localparam logic [1:0] OP_CHAR     = 2'd0;
  localparam logic [1:0] OP_SIGNED   = 2'd1;
  localparam logic [1:0] OP_UNSIGNED = 2'd2;

  typedef enum logic [1:0] {
    SEL_CHAR,
    SEL_MINUS,
    SEL_DIGIT
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      mul_step;
    logic      div_step;
    logic      emit;
    char_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic quot_zero;
    logic last_digit;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### sv/tcdw_if.sv
// Valid/ready channel interfaces of the console writer: input items,
// cell writes and the attribute write port. Depends on nothing.
`default_nettype none

interface tcdw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  char_code;
  logic [31:0] number;

  modport source (output valid, op, char_code, number, input ready);
  modport sink   (input valid, op, char_code, number, output ready);
endinterface

interface tcdw_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cell_offset;
  logic [7:0]  char_byte;
  logic [7:0]  attr_byte;
  logic        last;

  modport source (output valid, cell_offset, char_byte, attr_byte, last, input ready);
  modport sink   (input valid, cell_offset, char_byte, attr_byte, last, output ready);
endinterface

interface tcdw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### sv/tcdw_ctrl.sv
// Sequencer of the console writer: walks load, digit conversion and
// character emission. Depends on tcdw_pkg for command and status types.
`default_nettype none

module tcdw_ctrl
  import tcdw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] op_i,
  output logic            in_ready_o,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SIGN,
    S_DIGIT,
    S_CHAR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.sel    = SEL_CHAR;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (op_i)
            OP_CHAR:     state_d = S_CHAR;
            OP_SIGNED:   state_d = S_MUL;
            OP_UNSIGNED: state_d = S_MUL;
            default:     state_d = S_IDLE;  // unused op: drop the beat
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.quot_zero) begin
          state_d = sts_i.neg ? S_SIGN : S_DIGIT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_MINUS;
          state_d    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_DIGIT;
          if (sts_i.last_digit) begin
            state_d = S_IDLE;
          end
        end
      end
      S_CHAR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_CHAR;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/tcdw_datapath.sv
// Datapath of the console writer: magnitude, reciprocal divide by ten,
// digit stack, cursor and the output register. Depends on tcdw_pkg.
`default_nettype none

module tcdw_datapath
  import tcdw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [31:0] number_i,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [OFF_W-1:0] cell_offset_o,
  output logic [7:0]       char_byte_o,
  output logic [7:0]       attr_byte_o,
  output logic             last_o
);

  logic [7:0]       attr_q;
  logic [7:0]       char_q;
  logic             neg_q;
  logic [31:0]      mag_q;
  logic [63:0]      prod_q;
  logic [3:0]       digs_q [MAX_DIGITS];
  logic [CNT_W-1:0] cnt_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             out_valid_q;
  logic [OFF_W-1:0] off_q;
  logic [7:0]       ch_out_q;
  logic [7:0]       attr_out_q;
  logic             last_q;

  logic             in_neg;
  logic [28:0]      quot;
  logic [31:0]      quot10;
  logic [31:0]      rem_full;
  logic [7:0]       ch;
  logic             ch_last;
  logic             is_nl;
  logic             wrap;
  logic [COL_W-1:0] col_wr;
  logic [ROW_W-1:0] row_adv;
  logic [ROW_W-1:0] row_wr;
  logic [OFF_W-1:0] lin;
  logic             out_free;

  assign in_neg   = (op_i == OP_SIGNED) && number_i[31];
  assign quot     = prod_q[63:RECIP_SHR];
  assign quot10   = ({3'b000, quot} << 3) + ({3'b000, quot} << 1);
  assign rem_full = mag_q - quot10;
  assign out_free = !out_valid_q || out_ready_i;

  // Select the character of this emit and its last flag
  always_comb begin
    case (cmd_i.sel)
      SEL_CHAR: begin
        ch      = char_q;
        ch_last = 1'b1;
      end
      SEL_MINUS: begin
        ch      = ASCII_MINUS;
        ch_last = 1'b0;
      end
      SEL_DIGIT: begin
        ch      = ASCII_ZERO + {4'b0000, digs_q[0]};
        ch_last = (cnt_q == CNT_W'(1));
      end
      default: begin
        ch      = char_q;
        ch_last = 1'b1;
      end
    endcase
  end

  // Cursor step: wrap the line first, then the screen
  always_comb begin
    is_nl   = (ch == ASCII_NL);
    wrap    = is_nl || (col_q >= COL_W'(COLUMNS));
    col_wr  = wrap ? '0 : col_q;
    row_adv = (wrap && (row_q < ROW_W'(LINES))) ? row_q + ROW_W'(1) : row_q;
    row_wr  = (row_adv >= ROW_W'(LINES)) ? '0 : row_adv;
    lin     = OFF_W'(row_wr) * OFF_W'(COLUMNS) + OFF_W'(col_wr);
    col_d   = col_q;
    row_d   = row_q;
    if (cmd_i.emit) begin
      if (is_nl) begin
        col_d = col_wr;
        row_d = row_adv;
      end else begin
        col_d = col_wr + COL_W'(1);
        row_d = row_wr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ATTR_RESET;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_data_i;
      end
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.emit && (cmd_i.sel == SEL_DIGIT)) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.emit && !is_nl) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= char_code_i;
      neg_q  <= in_neg;
      mag_q  <= in_neg ? (32'd0 - number_i) : number_i;
    end
    if (cmd_i.mul_step) begin
      prod_q <= {32'd0, mag_q} * {32'd0, RECIP10};
    end
    // Push the new low digit; the top of the stack ends up most significant
    if (cmd_i.div_step) begin
      mag_q     <= {3'b000, quot};
      digs_q[0] <= rem_full[3:0];
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digs_q[i] <= digs_q[i-1];
      end
    end
    if (cmd_i.emit && (cmd_i.sel == SEL_DIGIT)) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        digs_q[i] <= digs_q[i+1];
      end
    end
    if (cmd_i.emit && !is_nl) begin
      off_q      <= {lin[OFF_W-2:0], 1'b0};
      ch_out_q   <= ch;
      attr_out_q <= attr_q;
      last_q     <= ch_last;
    end
  end

  assign sts_o.neg        = neg_q;
  assign sts_o.quot_zero  = (quot == '0);
  assign sts_o.last_digit = (cnt_q == CNT_W'(1));
  assign sts_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign cell_offset_o = off_q;
  assign char_byte_o   = ch_out_q;
  assign attr_byte_o   = attr_out_q;
  assign last_o        = last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("emit while the output register is still full");

  a_digit_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (cmd_i.sel == SEL_DIGIT)) |-> (cnt_q != '0))
    else $error("digit emitted from an empty digit stack");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (cnt_q < CNT_W'(MAX_DIGITS)))
    else $error("digit stack overflow");

  a_cursor_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !is_nl) |=> (col_q != '0) && (col_q <= COL_W'(COLUMNS)))
    else $error("column out of range after a cell write");

endmodule

`default_nettype wire

### sv/text_console_decimal_writer_top.sv
// Top level of the text console decimal writer: sequencer plus datapath.
// Depends on tcdw_pkg, the channel interfaces, tcdw_ctrl and tcdw_datapath.
//
// Usage:
//   in_chan_i  : input beats (op, char_code, number). op selects a character,
//                a signed or an unsigned 32-bit decimal; unused op is dropped.
//   out_chan_o : one beat per cell write (cell_offset, char_byte, attr_byte,
//                last); last marks the final cell caused by an input beat.
//                A newline moves the cursor and writes no cell.
//   cfg_i      : attribute byte write, always ready; write it only while idle.
// Timing:
//   in_chan_i.ready is high only when the sequencer is idle.
//   A character is accepted, then emitted into the output register.
//   A number is converted one digit at a time: a step in the shared
//   reciprocal multiplier, then a quotient/remainder step; then the minus
//   sign, if any, and the digits are emitted, one cell write each.
// Reset clears the cursor to the top-left cell, sets the attribute to 7 and
// empties the output register. When the receiver stalls, the output register
// holds its beat and emission waits; the cursor advances only on emit.
`default_nettype none

module text_console_decimal_writer_top
  import tcdw_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcdw_in_if.sink    in_chan_i,
  tcdw_out_if.source out_chan_o,
  tcdw_cfg_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;

  // Attribute writes never stall
  assign cfg_i.ready = 1'b1;

  tcdw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .op_i       (in_chan_i.op),
    .in_ready_o (in_chan_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcdw_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (in_chan_i.op),
    .char_code_i   (in_chan_i.char_code),
    .number_i      (in_chan_i.number),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (out_chan_o.ready),
    .out_valid_o   (out_chan_o.valid),
    .cell_offset_o (out_chan_o.cell_offset),
    .char_byte_o   (out_chan_o.char_byte),
    .attr_byte_o   (out_chan_o.attr_byte),
    .last_o        (out_chan_o.last)
  );

endmodule

`default_nettype wire

### bench/text_console_decimal_writer_top_test.sv
// Self-checking bench for text_console_decimal_writer_top: drives print beats,
// predicts every cell write with a cursor model and compares the output beats.
// Depends on tcdw_pkg, the channel interfaces in tcdw_if.sv and the top level.

module text_console_decimal_writer_top_test;
  import tcdw_pkg::*;

  // The block drops this op code without touching the cursor
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Watchdog limit for the whole run, with room for heavy stalls
  localparam int CYCLE_LIMIT     = 300_000;
  // Longest item is a ten digit negative number
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [31:0] number;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] cell_offset;
    logic [7:0]       char_byte;
    logic [7:0]       attr_byte;
    logic             last;
  } cell_t;

  typedef enum {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_e;

  // Screen model: cursor, attribute and the cell writes still to come
  class console_screen;
    logic [7:0]       attr;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    cell_t            cells_due[$];
    int               errors;

    function new();
      attr   = ATTR_RESET;
      col    = '0;
      row    = '0;
      errors = 0;
    endfunction

    function void set_attr(input logic [7:0] value);
      attr = value;
    endfunction

    function int outstanding();
      return cells_due.size();
    endfunction

    // Move the cursor for one character and queue its cell, if any
    function void put_char(input logic [7:0] ch);
      cell_t c;
      int    off;
      if (ch == ASCII_NL || col >= COLUMNS) begin
        col = '0;
        if (row < LINES) row = row + 1'b1;
      end
      if (ch == ASCII_NL) return;
      if (row >= LINES) row = '0;
      off           = (col + row * COLUMNS) * 2;
      c.cell_offset = off[OFF_W-1:0];
      c.char_byte   = ch;
      c.attr_byte   = attr;
      c.last        = 1'b0;
      cells_due.push_back(c);
      col = col + 1'b1;
    endfunction

    // Digits of a magnitude, most significant first, no leading zeros
    function void put_decimal(input logic [31:0] mag);
      logic [3:0]  digs [MAX_DIGITS];
      logic [31:0] rem;
      int          cnt;
      cnt = 0;
      do begin
        rem       = mag % 10;
        digs[cnt] = rem[3:0];
        mag       = mag / 10;
        cnt++;
      end while (mag != 0 && cnt < MAX_DIGITS);
      while (cnt > 0) begin
        cnt--;
        put_char(ASCII_ZERO + {4'd0, digs[cnt]});
      end
    endfunction

    // Note an accepted input beat: queue the cells it will write
    function void print_item(input in_item_t it);
      int          prior_cnt;
      logic [31:0] mag;
      prior_cnt = cells_due.size();
      case (it.op)
        OP_CHAR: put_char(it.char_code);
        OP_SIGNED: begin
          mag = it.number;
          if (it.number[31]) begin
            put_char(ASCII_MINUS);
            mag = 32'd0 - it.number;
          end
          put_decimal(mag);
        end
        OP_UNSIGNED: put_decimal(it.number);
        default: ;
      endcase
      if (cells_due.size() > prior_cnt) cells_due[cells_due.size() - 1].last = 1'b1;
    endfunction

    // Compare an accepted cell beat with the oldest queued cell
    function void match_cell(input cell_t got);
      cell_t exp;
      if (cells_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected cell beat: offset %0d char %02h attr %02h last %0b",
                   got.cell_offset, got.char_byte, got.attr_byte, got.last);
        return;
      end
      exp = cells_due.pop_front();
      if (got.cell_offset !== exp.cell_offset || got.char_byte !== exp.char_byte ||
          got.attr_byte !== exp.attr_byte || got.last !== exp.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("cell mismatch: expected offset %0d char %02h attr %02h last %0b",
                   exp.cell_offset, exp.char_byte, exp.attr_byte, exp.last);
          $display("               got      offset %0d char %02h attr %02h last %0b",
                   got.cell_offset, got.char_byte, got.attr_byte, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_off_req;
  int   cycle_count;

  console_screen screen = new();

  tcdw_in_if  in_chan ();
  tcdw_out_if out_chan ();
  tcdw_cfg_if cfg_chan ();

  text_console_decimal_writer_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_i      (cfg_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up if the run stalls
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("text_console_decimal_writer_top_test: errors");
    $finish;
  end

  // Cell sink: check every accepted beat, then pick ready for the next edge.
  // Ready follows segments of open, choppy or slow behavior; a hold-off
  // request from the stimulus side forces a long stall counted here.
  initial begin : cell_sink
    sink_mode_e mode;
    int         seg_left;
    int         hold_left;
    cell_t      got;
    mode      = SINK_OPEN;
    seg_left  = 0;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.cell_offset = out_chan.cell_offset;
        got.char_byte   = out_chan.char_byte;
        got.attr_byte   = out_chan.attr_byte;
        got.last        = out_chan.last;
        screen.match_cell(got);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (seg_left == 0) begin
        mode     = sink_mode_e'($urandom_range(0, 2));
        seg_left = $urandom_range(10, 150);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   out_chan.ready <= 1'b1;
          SINK_CHOPPY: out_chan.ready <= ($urandom_range(0, 1) == 1);
          default:     out_chan.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one beat and hold it until accepted; valid stays high afterwards
  // so back-to-back beats need no extra edge.
  task automatic send_item(input in_item_t it);
    in_chan.valid     <= 1'b1;
    in_chan.op        <= it.op;
    in_chan.char_code <= it.char_code;
    in_chan.number    <= it.number;
    do begin
      @(posedge clk);
    end while (!in_chan.ready);
    screen.print_item(it);
  endtask

  // Write the attribute register; only called while the block is idle
  task automatic write_attr(input logic [7:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    screen.set_attr(value);
  endtask

  // Hold off until every queued cell is out, then let trailing work finish
  task automatic wait_drained();
    while (screen.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick         = $urandom_range(0, 99);
    it.char_code = 8'($urandom_range(0, 255));
    it.number    = $urandom;
    // Mix full-width values with shifted ones to vary the digit count
    if ($urandom_range(0, 1) == 1) it.number = it.number >> $urandom_range(0, 31);
    if (pick < 35) begin
      it.op = OP_CHAR;
      if ($urandom_range(0, 3) == 0) it.char_code = ASCII_NL;
    end else if (pick < 65) begin
      it.op = OP_SIGNED;
      if ($urandom_range(0, 2) == 0) it.number = 32'd0 - it.number;
    end else if (pick < 95) begin
      it.op = OP_UNSIGNED;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // Stream random beats in bursts with gaps of random length. Runs of
  // newlines push the row to the bottom and into saturation. Dropped op
  // codes do not count toward n.
  task automatic stream_items(input int n);
    int       done_cnt;
    int       burst;
    int       gap;
    int       nl_left;
    in_item_t it;
    done_cnt = 0;
    nl_left  = 0;
    burst    = $urandom_range(1, 16);
    while (done_cnt < n) begin
      if (nl_left == 0 && $urandom_range(0, 24) == 0) nl_left = $urandom_range(4, 30);
      if (nl_left > 0) begin
        it = in_item_t'{OP_CHAR, ASCII_NL, $urandom};
        nl_left--;
      end else begin
        it = random_item();
      end
      send_item(it);
      if (it.op != OP_UNUSED) done_cnt++;
      burst--;
      if (burst == 0) begin
        in_chan.valid <= 1'b0;
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
    end
    in_chan.valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n              = 1'b0;
    hold_off_req       = 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.op        <= OP_CHAR;
    in_chan.char_code <= 8'h00;
    in_chan.number    <= 32'h0;
    cfg_chan.valid    <= 1'b0;
    cfg_chan.data     <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset attribute: byte extremes, newline
    // handling, zero, the most negative signed value and width extremes.
    send_item(in_item_t'{OP_CHAR, 8'h48, 32'hFFFF_FFFF});
    send_item(in_item_t'{OP_CHAR, 8'h00, 32'h0});
    send_item(in_item_t'{OP_CHAR, 8'hFF, 32'h0});
    send_item(in_item_t'{OP_CHAR, ASCII_NL, 32'h0});
    send_item(in_item_t'{OP_CHAR, 8'h7E, 32'h0});
    send_item(in_item_t'{OP_SIGNED, 8'hFF, 32'h0});
    send_item(in_item_t'{OP_SIGNED, 8'h00, 32'hFFFF_FFFF});
    send_item(in_item_t'{OP_SIGNED, 8'h0A, 32'h8000_0000});
    send_item(in_item_t'{OP_SIGNED, 8'h00, 32'h7FFF_FFFF});
    send_item(in_item_t'{OP_SIGNED, 8'h00, 32'h8000_0001});
    send_item(in_item_t'{OP_SIGNED, 8'h00, 32'hFFFF_FFF6});
    send_item(in_item_t'{OP_UNSIGNED, 8'h00, 32'hFFFF_FFFF});
    send_item(in_item_t'{OP_UNSIGNED, 8'hFF, 32'h0});
    send_item(in_item_t'{OP_UNSIGNED, 8'h00, 32'd9});
    send_item(in_item_t'{OP_UNSIGNED, 8'h00, 32'd10});
    send_item(in_item_t'{OP_UNSIGNED, 8'h00, 32'd1_000_000_000});
    send_item(in_item_t'{OP_UNUSED, 8'h41, 32'h1234_5678});
    send_item(in_item_t'{OP_CHAR, ASCII_NL, 32'h0});
    send_item(in_item_t'{OP_CHAR, ASCII_NL, 32'h0});
    send_item(in_item_t'{OP_CHAR, 8'h5A, 32'h0});
    in_chan.valid <= 1'b0;
    wait_drained();

    // Top attribute value, random traffic
    write_attr(8'hFF);
    stream_items(60);
    wait_drained();

    // Stall the sink for a long stretch while beats keep coming, so the
    // block backs up into its input; then pause until all cells are out.
    hold_off_req = 1'b1;
    for (int i = 0; i < 25; i++) send_item(random_item());
    in_chan.valid <= 1'b0;
    wait_drained();

    // Bottom attribute value
    write_attr(8'h00);
    stream_items(60);
    wait_drained();

    // Some value in between
    write_attr(8'($urandom_range(1, 254)));
    stream_items(55);
    wait_drained();

    if (screen.errors == 0 && screen.outstanding() == 0) begin
      $display("text_console_decimal_writer_top_test: clean");
    end else begin
      $display("text_console_decimal_writer_top_test: errors");
    end
    $finish;
  end

endmodule
